// File: rtl/tia_pkg.sv
// Package for the typed integer ALU: operation, type and status codes,
// width helpers. No dependencies.
package tia_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int DATA_W    = 64;
    localparam int DIV_STEPS = DATA_W;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_REM  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_XOR  = 4'd7;
    localparam logic [3:0] OP_SHL  = 4'd8;
    localparam logic [3:0] OP_SHR  = 4'd9;
    localparam logic [3:0] OP_EQ   = 4'd10;
    localparam logic [3:0] OP_NE   = 4'd11;
    localparam logic [3:0] OP_GT   = 4'd12;
    localparam logic [3:0] OP_GE   = 4'd13;
    localparam logic [3:0] OP_CAST = 4'd14;
    // float NaN check, not supported on integer types
    localparam logic [3:0] OP_NAN_CHK = 4'd15;

    localparam logic [3:0] CAST_PTR = 4'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO    = 3'd2;
    localparam logic [2:0] ST_DIV_OVF     = 3'd3;
    localparam logic [2:0] ST_BAD_CAST    = 3'd4;

    typedef logic [DATA_W-1:0] word_t;

    // element width for a size code (8 << code), limited to MAX_WIDTH
    function automatic logic [6:0] code_width(input logic [1:0] code);
        logic [6:0] w;
        w = 7'd8 << code;
        if (w > 7'(MAX_WIDTH))
        begin
            w = 7'(MAX_WIDTH);
        end
        return w;
    endfunction

    function automatic word_t width_mask(input logic [6:0] w);
        word_t m;
        if (w >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (word_t'(1) << w[5:0]) - word_t'(1);
        end
        return m;
    endfunction

endpackage

// File: rtl/tia_req_if.sv
// Request and response channel interfaces for the typed integer ALU.
// No dependencies.
interface tia_req_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           mode;
    logic [2:0]           elem_type;
    logic [63:0]          operand_a;
    logic [63:0]          operand_b;
    logic [3:0]           cast_target;

    modport source (output valid, mode, elem_type, operand_a, operand_b, cast_target,
                    input ready);
    modport sink   (input valid, mode, elem_type, operand_a, operand_b, cast_target,
                    output ready);
endinterface

interface tia_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic [2:0]  status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

// File: rtl/typed_integer_alu_top.sv
// A request passes through 68 register stages (two input stages, setup, 64 divide steps,
// output); throughput one request per cycle while the response is not stalled.
// Depth is set by the 64-stage pipelined restoring divider, one quotient bit per stage.
// All stages advance together; a stalled response holds the whole pipe in place.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
// Depends on tia_pkg, tia_req_if, tia_rsp_if.
module typed_integer_alu_top (
    input  logic clk,
    input  logic rst_n,
    tia_req_if.sink   req,
    tia_rsp_if.source rsp
);
    import tia_pkg::*;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] wcode;
        logic       sgn;
        logic [3:0] tgt;
        word_t      a;
        word_t      b;
    } opnd_t;

    typedef struct packed {
        word_t      rem;
        word_t      quo;
        word_t      dvs;
        word_t      fast;
        logic [2:0] status;
        logic [1:0] wcode;
        logic       is_mul;
        logic       div_norm;
        logic       use_rem;
        logic       neg_q;
        logic       neg_r;
    } core_t;

    logic  adv;
    logic  v0_reg, v1_reg, vo_reg;
    logic  cv_reg [0:DIV_STEPS];
    opnd_t r0_reg, r1_reg, r1_next;
    core_t c_reg  [0:DIV_STEPS];
    core_t c0_next;
    core_t c_next [1:DIV_STEPS];
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next, p2_reg, p2_next;
    word_t res_reg, res_next;
    logic [2:0] st_reg;

    assign adv       = !vo_reg || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vo_reg;
    assign rsp.result = res_reg;
    assign rsp.status = st_reg;

    // extend operands by element type
    always_comb
    begin
        word_t m;
        logic  sa, sb;
        m  = width_mask(code_width(r0_reg.wcode));
        sa = |(r0_reg.a & m & ~(m >> 1));
        sb = |(r0_reg.b & m & ~(m >> 1));
        r1_next   = r0_reg;
        r1_next.a = (r0_reg.a & m) | ((r0_reg.sgn && sa) ? ~m : '0);
        r1_next.b = (r0_reg.b & m) | ((r0_reg.sgn && sb) ? ~m : '0);
    end

    // fast ops, multiply partial products, divider setup
    always_comb
    begin
        word_t      m, a, b, r, s, smin, tm;
        logic [6:0] w;
        logic       neg_a, neg_b, gt;
        logic [2:0] st;
        a     = r1_reg.a;
        b     = r1_reg.b;
        w     = code_width(r1_reg.wcode);
        m     = width_mask(w);
        s     = b & m;
        smin  = ~(m >> 1);
        tm    = '0;
        neg_a = r1_reg.sgn && a[63];
        neg_b = r1_reg.sgn && b[63];
        gt    = r1_reg.sgn ? ($signed(a) > $signed(b)) : (a > b);
        st    = ST_OK;
        r     = '0;
        c0_next          = '0;
        c0_next.wcode    = r1_reg.wcode;
        case (r1_reg.mode)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: c0_next.is_mul = 1'b1;
            OP_DIV, OP_REM:
            begin
                if (b == '0)
                begin
                    st = ST_DIV_ZERO;
                end
                else if (r1_reg.sgn && a == smin && b == '1)
                begin
                    st = ST_DIV_OVF;
                    r  = (r1_reg.mode == OP_DIV) ? a : '0;
                end
                else
                begin
                    c0_next.div_norm = 1'b1;
                end
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_SHL, OP_SHR:
            begin
                if (s >= word_t'(w))
                begin
                    r = (r1_reg.mode == OP_SHR && neg_a) ? '1 : '0;
                end
                else if (r1_reg.mode == OP_SHL)
                begin
                    r = a << s[5:0];
                end
                else if (r1_reg.sgn)
                begin
                    r = $signed(a) >>> s[5:0];
                end
                else
                begin
                    r = a >> s[5:0];
                end
            end
            OP_EQ: r = word_t'(a == b);
            OP_NE: r = word_t'(a != b);
            OP_GT: r = word_t'(gt);
            OP_GE: r = word_t'(gt || a == b);
            OP_CAST:
            begin
                if (r1_reg.tgt < CAST_PTR)
                begin
                    tm = width_mask(code_width(r1_reg.tgt[1:0]));
                end
                else
                begin
                    tm = width_mask(code_width(2'd2));
                end
                if (r1_reg.tgt > CAST_PTR)
                begin
                    st = ST_BAD_CAST;
                    tm = '0;
                end
                // cast keeps target width, not element width
                m = tm;
                r = a;
            end
            default: st = ST_UNSUPPORTED;
        endcase
        c0_next.fast    = r & m;
        c0_next.status  = st;
        c0_next.use_rem = (r1_reg.mode == OP_REM);
        c0_next.neg_q   = neg_a ^ neg_b;
        c0_next.neg_r   = neg_a;
        c0_next.rem     = '0;
        c0_next.quo     = neg_a ? word_t'(0) - a : a;
        c0_next.dvs     = neg_b ? word_t'(0) - b : b;
        p0_next = a[31:0] * b[31:0];
        p1_next = 32'(a[31:0] * b[63:32]);
        p2_next = 32'(a[63:32] * b[31:0]);
    end

    // one restoring divide step per stage; multiply sum merges in the first
    always_comb
    begin
        logic [64:0] t, d;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            t = {c_reg[k-1].rem, c_reg[k-1].quo[63]};
            d = t - {1'b0, c_reg[k-1].dvs};
            c_next[k]     = c_reg[k-1];
            c_next[k].rem = d[64] ? t[63:0] : d[63:0];
            c_next[k].quo = {c_reg[k-1].quo[62:0], !d[64]};
            if (k == 1 && c_reg[0].is_mul)
            begin
                c_next[k].fast = (p0_reg + {p1_reg + p2_reg, 32'd0})
                                 & width_mask(code_width(c_reg[0].wcode));
            end
        end
    end

    always_comb
    begin
        core_t c;
        word_t q, rm;
        c  = c_reg[DIV_STEPS];
        q  = c.neg_q ? word_t'(0) - c.quo : c.quo;
        rm = c.neg_r ? word_t'(0) - c.rem : c.rem;
        if (c.div_norm)
        begin
            res_next = (c.use_rem ? rm : q) & width_mask(code_width(c.wcode));
        end
        else
        begin
            res_next = c.fast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg    <= req.valid;
            v1_reg    <= v0_reg;
            cv_reg[0] <= v1_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                cv_reg[k] <= cv_reg[k-1];
            end
            vo_reg <= cv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg.mode  <= req.mode;
            r0_reg.wcode <= req.elem_type[1:0];
            r0_reg.sgn   <= !req.elem_type[2];
            r0_reg.tgt   <= req.cast_target;
            r0_reg.a     <= req.operand_a;
            r0_reg.b     <= req.operand_b;
            r1_reg       <= r1_next;
            p0_reg       <= p0_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            c_reg[0]     <= c0_next;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                c_reg[k] <= c_next[k];
            end
            res_reg <= res_next;
            st_reg  <= c_reg[DIV_STEPS].status;
        end
    end

endmodule
